[sv/assert_macros.svh]
// Assertion macros shared by the gesture detector RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the cycle after.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/tbgd_pkg.sv]
// Shared types, constants and helpers for the touch button gesture detector.
// Used by tbgd_div and touch_button_gesture_detector_top.
package tbgd_pkg;

    // Time stamps wrap modulo 2^TIME_W
    localparam int TIME_W    = 32;
    localparam int READ_W    = 24;
    localparam int SUM_W     = 32;
    localparam int CNT_W     = 8;
    localparam int THR_W     = 24;
    localparam int MS_W      = 16;
    localparam int KIND_W    = 2;
    localparam int STEP_W    = $clog2(SUM_W);

    localparam logic [THR_W-1:0] THR_RESET   = THR_W'(350);
    localparam logic [MS_W-1:0]  EVAL_RESET  = MS_W'(25);
    localparam logic [MS_W-1:0]  LONG_RESET  = MS_W'(500);
    localparam logic [MS_W-1:0]  GAP_RESET   = MS_W'(250);
    localparam logic [CNT_W-1:0] CNT_MAX     = '1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TOUCH_THRESHOLD = 2'd0,
        REG_EVAL_INTERVAL   = 2'd1,
        REG_LONG_PRESS      = 2'd2,
        REG_MULTI_CLICK_GAP = 2'd3
    } cfg_reg_t;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        EV_CLICK      = 2'd0,
        EV_HOLD_START = 2'd1,
        EV_HOLDING    = 2'd2
    } event_kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EVAL,
        ST_REPORT
    } seq_state_t;

    // Wrapping time difference
    function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now_t,
                                                  input logic [TIME_W-1:0] then_t);
        return now_t - then_t;
    endfunction

    // Widen a millisecond register to time width
    function automatic logic [TIME_W-1:0] ms_to_time(input logic [MS_W-1:0] ms);
        return {{(TIME_W-MS_W){1'b0}}, ms};
    endfunction

endpackage

[sv/tbgd_div.sv]
// Iterative restoring divider: 32-bit sum over 8-bit count, one bit a cycle.
// Depends on tbgd_pkg for widths.
module tbgd_div
    import tbgd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quot_reg, quot_next;
    logic [CNT_W-1:0]  dvsr_reg, dvsr_next;
    logic [CNT_W:0]    shifted;
    logic              q_bit;

    // Shift one dividend bit into the remainder and trial-subtract
    always_comb begin
        shifted    = {rem_reg, quot_reg[SUM_W-1]};
        q_bit      = shifted >= {1'b0, dvsr_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        dvsr_next  = dvsr_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quot_next = dividend;
            dvsr_next = divisor;
        end else if (busy_reg) begin
            rem_next  = q_bit ? CNT_W'(shifted - {1'b0, dvsr_reg}) : CNT_W'(shifted);
            quot_next = {quot_reg[SUM_W-2:0], q_bit};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[sv/touch_button_gesture_detector_top.sv]
// A failed reading is dropped in ST_IDLE; any other reading passes ST_CHECK and
// ST_REPORT, one with an average evaluation also ST_DIV (the 32-step shared
// divider) and ST_EVAL. One item at a time: s_tready is high only when idle.
// The result sits in an output register, so a new item is taken while it waits;
// an event that finds that register still full holds the sequencer until m_tready.
// Reset (aresetn, synchronous, active low) restores the register defaults and
// clears all gesture state and the accumulator.
`include "assert_macros.svh"

module touch_button_gesture_detector_top
    import tbgd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_addr,
    input  logic [THR_W-1:0]      cfg_wr_data,
    // Reading stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,   // charge_time[23:0], now_ms[55:24]
    input  logic                  s_tuser,   // read_failed
    // Event stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CNT_W-1:0]      m_tdata,   // click_count[7:0]
    output logic [KIND_W-1:0]     m_tuser    // event_kind[1:0]
);

    seq_state_t         state_reg, state_next;

    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [MS_W-1:0]    eval_ms_reg, eval_ms_next;
    logic [MS_W-1:0]    long_ms_reg, long_ms_next;
    logic [MS_W-1:0]    gap_ms_reg, gap_ms_next;

    logic               pressed_reg, pressed_next;
    logic               hold_first_reg, hold_first_next;
    logic               pending_reg, pending_next;
    logic [CNT_W-1:0]   clicks_reg, clicks_next;
    logic [TIME_W-1:0]  down_time_reg, down_time_next;
    logic [TIME_W-1:0]  up_time_reg, up_time_next;
    logic [TIME_W-1:0]  last_eval_reg, last_eval_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]  now_reg, now_next;

    logic               m_valid_reg, m_valid_next;
    event_kind_t        m_kind_reg, m_kind_next;
    logic [CNT_W-1:0]   m_count_reg, m_count_next;

    logic [READ_W-1:0]  in_charge;
    logic [TIME_W-1:0]  in_now;
    logic               in_accept;
    logic               out_free;
    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_quot;
    logic               is_long;
    logic               gap_over;

    assign in_charge = s_tdata[READ_W-1:0];
    assign in_now    = s_tdata[READ_W +: TIME_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign is_long   = elapsed(now_reg, down_time_reg) > ms_to_time(long_ms_reg);
    assign gap_over  = elapsed(now_reg, up_time_reg) > ms_to_time(gap_ms_reg);

    // Shared divider for the average charge time
    tbgd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Configuration writes
    always_comb begin
        thr_next     = thr_reg;
        eval_ms_next = eval_ms_reg;
        long_ms_next = long_ms_reg;
        gap_ms_next  = gap_ms_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_TOUCH_THRESHOLD: thr_next     = cfg_wr_data;
                REG_EVAL_INTERVAL:   eval_ms_next = cfg_wr_data[MS_W-1:0];
                REG_LONG_PRESS:      long_ms_next = cfg_wr_data[MS_W-1:0];
                REG_MULTI_CLICK_GAP: gap_ms_next  = cfg_wr_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: accumulate, evaluate the average, then report an event
    always_comb begin
        state_next      = state_reg;
        pressed_next    = pressed_reg;
        hold_first_next = hold_first_reg;
        pending_next    = pending_reg;
        clicks_next     = clicks_reg;
        down_time_next  = down_time_reg;
        up_time_next    = up_time_reg;
        last_eval_next  = last_eval_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        now_next        = now_reg;
        m_kind_next     = m_kind_reg;
        m_count_next    = m_count_reg;
        m_valid_next    = m_tready ? 1'b0 : m_valid_reg;
        div_start       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                // Drop failed readings, accumulate good ones until full
                if (in_accept && !s_tuser) begin
                    if (count_reg != CNT_MAX) begin
                        sum_next   = sum_reg + {{(SUM_W-READ_W){1'b0}}, in_charge};
                        count_next = count_reg + 1'b1;
                    end
                    now_next   = in_now;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (elapsed(now_reg, last_eval_reg) >= ms_to_time(eval_ms_reg)) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_REPORT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // Detect touch-up or touch-down, then clear the accumulator
                if (pressed_reg && (div_quot < {{(SUM_W-THR_W){1'b0}}, thr_reg})) begin
                    pressed_next    = 1'b0;
                    hold_first_next = 1'b0;
                    if (is_long) begin
                        clicks_next = '0;
                    end else if (clicks_reg != CNT_MAX) begin
                        clicks_next = clicks_reg + 1'b1;
                    end
                    up_time_next = now_reg;
                    pending_next = 1'b1;
                end else if (!pressed_reg &&
                             (div_quot > {{(SUM_W-THR_W){1'b0}}, thr_reg})) begin
                    pressed_next    = 1'b1;
                    hold_first_next = 1'b1;
                    down_time_next  = now_reg;
                end
                sum_next       = '0;
                count_next     = '0;
                last_eval_next = now_reg;
                state_next     = ST_REPORT;
            end
            ST_REPORT: begin
                // Hold here until the output register can take the event
                if (!pressed_reg && pending_reg && gap_over) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = EV_CLICK;
                        m_count_next = clicks_reg;
                        clicks_next  = '0;
                        pending_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end else if (pressed_reg && is_long) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        m_kind_next     = hold_first_reg ? EV_HOLD_START : EV_HOLDING;
                        m_count_next    = clicks_reg;
                        hold_first_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and gesture state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THR_RESET;
            eval_ms_reg    <= EVAL_RESET;
            long_ms_reg    <= LONG_RESET;
            gap_ms_reg     <= GAP_RESET;
            pressed_reg    <= 1'b0;
            hold_first_reg <= 1'b0;
            pending_reg    <= 1'b0;
            clicks_reg     <= '0;
            down_time_reg  <= '0;
            up_time_reg    <= '0;
            last_eval_reg  <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            eval_ms_reg    <= eval_ms_next;
            long_ms_reg    <= long_ms_next;
            gap_ms_reg     <= gap_ms_next;
            pressed_reg    <= pressed_next;
            hold_first_reg <= hold_first_next;
            pending_reg    <= pending_next;
            clicks_reg     <= clicks_next;
            down_time_reg  <= down_time_next;
            up_time_reg    <= up_time_next;
            last_eval_reg  <= last_eval_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        m_kind_reg  <= m_kind_next;
        m_count_reg <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_count_reg;
    assign m_tuser  = m_kind_reg;

    // A divider result only arrives while the sequencer waits for it
    `ASSERT_IMPL(a_div_done_in_div, div_done, state_reg == ST_DIV)
    // The first-hold flag lives only inside a press
    `ASSERT_IMPL(a_hold_first_pressed, hold_first_reg, pressed_reg)
    // A good reading always moves on to the interval check
    `ASSERT_NEXT(a_accept_to_check, in_accept && !s_tuser, state_reg == ST_CHECK)

endmodule
